/* rtl/spq_pkg.sv */
// sorted priority queue: shared types and constants
// op codes, status codes and the controller to datapath command and status structs
package spq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [STAT_W-1:0] stat_code_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_CLEAR  = 2'd2;

   localparam stat_code_type STAT_OK    = 2'd0;
   localparam stat_code_type STAT_EMPTY = 2'd1;
   localparam stat_code_type STAT_FULL  = 2'd2;

   // commands from the controller, valid in the cycle of a req transfer
   typedef struct packed {
      logic          load;
      logic          insert;
      logic          remove;
      logic          clear;
      stat_code_type code;
   } spq_cmd_type;

   // queue status back to the controller
   typedef struct packed {
      logic full;
      logic empty;
   } spq_stat_type;

endpackage

/* rtl/spq_req_if.sv */
// request channel: valid/ready handshake with op, priority and element
// depends on spq_pkg
interface spq_req_if
   import spq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   op_type                   op;
   logic signed [DATA_W-1:0] priority_req;
   logic signed [DATA_W-1:0] element;

   modport source (output valid, output op, output priority_req, output element,
                   input ready);
   modport sink   (input valid, input op, input priority_req, input element,
                   output ready);
endinterface

/* rtl/spq_rsp_if.sv */
// response channel: valid/ready handshake with popped entry, status, occupancy
// depends on spq_pkg; occupancy width follows the queue depth
interface spq_rsp_if
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) ();
   localparam int CntW = $clog2(DEPTH + 1);

   logic                     valid;
   logic                     ready;
   logic                     popped;
   logic signed [DATA_W-1:0] head_element;
   logic signed [DATA_W-1:0] head_priority;
   stat_code_type            status;
   logic [CntW-1:0]          occupancy;

   modport source (output valid, output popped, output head_element,
                   output head_priority, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input popped, input head_element,
                   input head_priority, input status, input occupancy,
                   output ready);
endinterface

/* rtl/spq_ctrl.sv */
// sorted priority queue controller: handshake and op decode
// depends on spq_pkg; drives commands into spq_datapath
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  op_type       req_op,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff, state_in;
   logic accept;

   // output register frees up in the same cycle its transfer completes
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_HOLD;
      end else if (rsp_ready) begin
         state_in = ST_IDLE;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.code   = STAT_OK;
      case (req_op)
         OP_INSERT: begin
            cmd.insert = accept && !stat.full;
            if (stat.full) cmd.code = STAT_FULL;
         end
         OP_REMOVE: begin
            cmd.remove = accept && !stat.empty;
            if (stat.empty) cmd.code = STAT_EMPTY;
         end
         OP_CLEAR: begin
            cmd.clear = accept;
         end
         default: begin
            cmd.code = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/spq_datapath.sv */
// sorted priority queue datapath: shift-register cell chain, count, response register
// depends on spq_pkg; commanded by spq_ctrl
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_cmd_type                         cmd,
   output spq_stat_type                        stat,
   input  logic signed [DATA_W-1:0]            in_priority,
   input  logic signed [DATA_W-1:0]            in_element,
   output logic                                out_popped,
   output logic signed [DATA_W-1:0]            out_element,
   output logic signed [DATA_W-1:0]            out_priority,
   output stat_code_type                       out_status,
   output logic [$clog2(DEPTH+1)-1:0]          out_occupancy
);

   localparam int CntW = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] prio_ff [DEPTH];
   logic signed [DATA_W-1:0] id_ff   [DEPTH];
   logic [CntW-1:0]          count_ff, count_in;
   logic [DEPTH-1:0]         after_pos;

   logic                     popped_ff;
   logic signed [DATA_W-1:0] head_id_ff, head_prio_ff;
   stat_code_type            status_ff;

   assign stat.full  = (count_ff == CntW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   // a cell lies at or after the insert slot if it is unused or holds a
   // strictly greater priority; monotone because the cells stay sorted
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign after_pos[i] = (count_ff <= CntW'(i)) || (in_priority < prio_ff[i]);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.insert && after_pos[i]) begin
            if (i == 0) begin
               prio_ff[i] <= in_priority;
               id_ff[i]   <= in_element;
            end else if (!after_pos[(i == 0) ? 0 : i-1]) begin
               prio_ff[i] <= in_priority;
               id_ff[i]   <= in_element;
            end else begin
               prio_ff[i] <= prio_ff[(i == 0) ? 0 : i-1];
               id_ff[i]   <= id_ff[(i == 0) ? 0 : i-1];
            end
         end else if (cmd.remove && (i < DEPTH-1)) begin
            prio_ff[i] <= prio_ff[(i < DEPTH-1) ? i+1 : i];
            id_ff[i]   <= id_ff[(i < DEPTH-1) ? i+1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response register, loaded on each req transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         popped_ff    <= cmd.remove;
         head_id_ff   <= cmd.remove ? id_ff[0]   : '0;
         head_prio_ff <= cmd.remove ? prio_ff[0] : '0;
         status_ff    <= cmd.code;
      end
   end

   assign out_popped    = popped_ff;
   assign out_element   = head_id_ff;
   assign out_priority  = head_prio_ff;
   assign out_status    = status_ff;
   assign out_occupancy = count_ff;

endmodule

/* rtl/sorted_priority_queue_top.sv */
// sorted priority queue top level: controller plus cell-chain datapath
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl, spq_datapath
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, priority_req, element
//   rsp      out  valid/ready   popped, head_element, head_priority, status, occupancy
//
// every op finishes in the cycle of its transfer; the response shows in the cycle after
// one item per cycle unless a stalled rsp blocks req: all cells compare against the new priority at once and shift
// req_ready stays high while the response register is empty or being drained
// a stalled rsp holds its payload and blocks the next req transfer
// reset is synchronous and empties the queue; cell contents are left as they are
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_op    (req.op),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .in_priority   (req.priority_req),
      .in_element    (req.element),
      .out_popped    (rsp.popped),
      .out_element   (rsp.head_element),
      .out_priority  (rsp.head_priority),
      .out_status    (rsp.status),
      .out_occupancy (rsp.occupancy)
   );

endmodule

/* bench/sorted_priority_queue_top_tb.sv */
// self-checking bench for sorted_priority_queue_top: directed and random insert, remove,
// clear and unused ops with a queue model in a scoreboard class
// depends on spq_pkg, spq_req_if, spq_rsp_if and the rtl of the queue
module sorted_priority_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int OCC_W  = $clog2(QDEPTH + 1);
   localparam int RANDOM_ITEMS = 1200;
   localparam int LONG_HOLD_CYCLES = 100;

   // op code that the block leaves without effect
   localparam op_type OP_NOP = 2'd3;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_type;
   typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_CLEAR} run_kind_type;

   typedef struct packed {
      logic                     popped;
      logic signed [DATA_W-1:0] head_element;
      logic signed [DATA_W-1:0] head_priority;
      stat_code_type            status;
      logic [OCC_W-1:0]         occupancy;
   } queue_result_type;

   class queue_scoreboard;
      logic signed [DATA_W-1:0] held_prio[$];
      logic signed [DATA_W-1:0] held_id[$];
      queue_result_type         due_results[$];
      int unsigned              fail_count;

      // work out the response of one accepted op and update the held entries
      function void predict_op(op_type op, logic signed [DATA_W-1:0] prio,
                               logic signed [DATA_W-1:0] elem);
         queue_result_type res;
         int               pos;
         res = '0;
         case (op)
            OP_INSERT: begin
               if (held_prio.size() >= QDEPTH) begin
                  res.status = STAT_FULL;
               end else begin
                  // goes behind every entry of equal or lower priority
                  pos = held_prio.size();
                  for (int i = 0; i < held_prio.size(); i++) begin
                     if (prio < held_prio[i]) begin
                        pos = i;
                        break;
                     end
                  end
                  held_prio.insert(pos, prio);
                  held_id.insert(pos, elem);
               end
            end
            OP_REMOVE: begin
               if (held_prio.size() == 0) begin
                  res.status = STAT_EMPTY;
               end else begin
                  res.popped        = 1'b1;
                  res.head_element  = held_id.pop_front();
                  res.head_priority = held_prio.pop_front();
               end
            end
            OP_CLEAR: begin
               held_prio.delete();
               held_id.delete();
            end
            default: ;
         endcase
         res.occupancy = OCC_W'(held_prio.size());
         due_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                  logic [DATA_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("rsp %s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
         end
      endfunction

      function void check_response(queue_result_type got);
         queue_result_type want;
         if (due_results.size() == 0) begin
            $error("rsp transfer with no result due");
            fail_count++;
            return;
         end
         want = due_results.pop_front();
         compare_field("popped", DATA_W'(want.popped), DATA_W'(got.popped));
         compare_field("head_element", want.head_element, got.head_element);
         compare_field("head_priority", want.head_priority, got.head_priority);
         compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
         compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
      endfunction

      function int unsigned waiting();
         return due_results.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   spq_req_if req_if ();
   spq_rsp_if #(.DEPTH(QDEPTH)) rsp_if ();

   sorted_priority_queue_top #(.DEPTH(QDEPTH)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   queue_scoreboard sb = new();

   rx_mode_type rx_mode = RX_ALWAYS;
   bit          long_hold_pending = 1'b0;
   int unsigned hold_left = 0;
   int unsigned rx_tick = 0;
   bit          tx_gaps_on = 1'b1;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // transfers seen at the rising edge; a response always belongs to an earlier request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_response({rsp_if.popped, rsp_if.head_element, rsp_if.head_priority,
                               rsp_if.status, rsp_if.occupancy});
         end
         if (req_if.valid && req_if.ready) begin
            sb.predict_op(req_if.op, req_if.priority_req, req_if.element);
         end
      end
   end

   // receiver stall pattern; a long hold-off is counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rx_tick++;
         case (rx_mode)
            RX_ALWAYS:  rsp_if.ready <= 1'b1;
            RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 9) < 7);
            RX_PATTERN: rsp_if.ready <= ((rx_tick % 5) < 3);
            default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic idle_req(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_if.valid        <= 1'b0;
         req_if.op           <= op_type'($urandom_range(0, 3));
         req_if.priority_req <= $urandom;
         req_if.element      <= $urandom;
      end
   endtask

   task automatic send(op_type op, logic signed [DATA_W-1:0] prio,
                       logic signed [DATA_W-1:0] elem);
      if (tx_gaps_on && burst_left == 0) begin
         idle_req($urandom_range(1, 5));
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.op           <= op;
      req_if.priority_req <= prio;
      req_if.element      <= elem;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (op != OP_NOP) items_sent++;
   endtask

   // ties, whole and fractional values, extremes and anything else
   function automatic logic signed [DATA_W-1:0] pick_priority();
      int v;
      v = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0, 1, 2: return v - 3;
         3:       return (v - 3) * 65536;
         4: begin
            case (v % 4)
               0:       return 32'h7fff_ffff;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic random_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)      send(OP_INSERT, pick_priority(), $urandom);
      else if (r < 90) send(OP_REMOVE, $urandom, $urandom);
      else if (r < 94) send(OP_CLEAR, $urandom, $urandom);
      else             send(OP_NOP, $urandom, $urandom);
   endtask

   initial begin
      run_kind_type kind;
      bit           hold_done;
      hold_done = 1'b0;
      req_if.valid        = 1'b0;
      req_if.op           = OP_INSERT;
      req_if.priority_req = '0;
      req_if.element      = '0;
      rsp_if.ready        = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty remove, extremes, ties in arrival order, unused op, clear
      send(OP_REMOVE, 32'h0, 32'h0);
      send(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      send(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      send(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_INSERT, 32'h0005_0000, 32'h1);
      send(OP_INSERT, 32'h0005_0000, 32'h2);
      send(OP_NOP, 32'h0005_0000, 32'h55);
      send(OP_INSERT, 32'h0005_0000, 32'h3);
      repeat (4) send(OP_REMOVE, 32'h0, 32'h0);
      send(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_REMOVE, 32'h0, 32'h0);
      send(OP_INSERT, 32'h0001_8000, 32'h1234_5678);
      send(OP_REMOVE, 32'h0, 32'h0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         if (!hold_done && items_sent >= RANDOM_ITEMS / 4) begin
            // sender keeps offering while the receiver holds off
            long_hold_pending = 1'b1;
            hold_done = 1'b1;
         end
         kind = run_kind_type'($urandom_range(0, 3));
         case (kind)
            RUN_FILL: begin
               repeat ($urandom_range(8, 20)) begin
                  if ($urandom_range(0, 19) == 0) send(OP_NOP, $urandom, $urandom);
                  else send(OP_INSERT, pick_priority(), $urandom);
               end
            end
            RUN_DRAIN: repeat ($urandom_range(4, 20)) send(OP_REMOVE, $urandom, $urandom);
            RUN_MIXED: repeat ($urandom_range(10, 40)) random_op();
            default: begin
               send(OP_CLEAR, $urandom, $urandom);
               repeat ($urandom_range(1, 6)) send(OP_INSERT, pick_priority(), $urandom);
            end
         endcase
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      rx_mode = RX_ALWAYS;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #500_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
